// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the gas leak safety interlock.
// Every macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define GLSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define GLSI_ASSERT_IMPLY(lbl, cond, cons, msg) \
  `GLSI_ASSERT(lbl, (cond) |-> (cons), msg)

`endif

// ----- rtl/glsi_pkg.sv -----
// Types and constants for the gas leak safety interlock.
// Used by glsi_step and by the top level; depends on nothing else.
package glsi_pkg;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_POLL  = 2'd1;
  localparam logic [1:0] MODE_FAN   = 2'd2;
  localparam logic [1:0] MODE_VALVE = 2'd3;

  localparam logic [1:0] REG_GAS_ALARM_LEVEL  = 2'd0;
  localparam logic [1:0] REG_GAS_CLEAR_LEVEL  = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE_TICKS   = 2'd2;
  localparam logic [1:0] REG_SERVO_HOLD_TICKS = 2'd3;

  localparam logic [9:0]  GAS_ALARM_LEVEL_RST  = 10'd400;
  localparam logic [9:0]  GAS_CLEAR_LEVEL_RST  = 10'd360;
  localparam logic [15:0] DEBOUNCE_TICKS_RST   = 16'd50;
  localparam logic [15:0] SERVO_HOLD_TICKS_RST = 16'd600;
  localparam logic [15:0] COUNT_MAX            = 16'hFFFF;

  typedef struct packed {
    logic [9:0]  gas_alarm_level;
    logic [9:0]  gas_clear_level;
    logic [15:0] debounce_ticks;
    logic [15:0] servo_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic        gas_alarm_on;
    logic        leak_alarm_on;
    logic        fan_running;
    logic        valve_closed_now;
    logic        last_pin_seen;
    logic        stable_pin;
    logic [15:0] quiet_count;
    logic        servo_active;
    logic [15:0] servo_count;
  } state_t;

  // Packed so that fan_drive lands in bit 0 of the output tdata.
  typedef struct packed {
    logic refused;
    logic valve_report;
    logic fan_report;
    logic leak_alarm_flag;
    logic gas_alarm_flag;
    logic servo_power;
    logic valve_shut;
    logic fan_drive;
  } result_t;

endpackage

// ----- rtl/gas_leak_safety_interlock_unit.sv -----
// Gas leak safety interlock: takes one item per clock cycle and returns one result per item,
// held in an output register that shows it the cycle after the input transfer. The input
// side is ready whenever that register is empty or being emptied in the same cycle, so the
// sustained rate is one item per cycle and only a stall at the output slows it down.
// Configuration writes are always taken, as cfg_ready is tied high. Depends on glsi_pkg and glsi_step.
`include "assert_macros.svh"

module gas_leak_safety_interlock_unit import glsi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [9:0] gas_sample, [10] pin_level, [11] command_on
  input  logic [1:0]  s_axis_tuser,  // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] fan_drive, [1] valve_shut, [2] servo_power, [3] gas_alarm_flag,
  // [4] leak_alarm_flag, [5] fan_report, [6] valve_report, [7] refused
  output logic [7:0]  m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  result_t result;
  result_t result_reg;
  logic    in_xfer;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gas_alarm_level  <= GAS_ALARM_LEVEL_RST;
      cfg.gas_clear_level  <= GAS_CLEAR_LEVEL_RST;
      cfg.debounce_ticks   <= DEBOUNCE_TICKS_RST;
      cfg.servo_hold_ticks <= SERVO_HOLD_TICKS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAS_ALARM_LEVEL:  cfg.gas_alarm_level  <= cfg_data[9:0];
        REG_GAS_CLEAR_LEVEL:  cfg.gas_clear_level  <= cfg_data[9:0];
        REG_DEBOUNCE_TICKS:   cfg.debounce_ticks   <= cfg_data;
        REG_SERVO_HOLD_TICKS: cfg.servo_hold_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  glsi_step u_step (
    .state      (state),
    .cfg        (cfg),
    .mode       (s_axis_tuser),
    .gas_sample (s_axis_tdata[9:0]),
    .pin_level  (s_axis_tdata[10]),
    .command_on (s_axis_tdata[11]),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.gas_alarm_on     <= 1'b0;
      state.leak_alarm_on    <= 1'b0;
      state.fan_running      <= 1'b0;
      state.valve_closed_now <= 1'b0;
      state.last_pin_seen    <= 1'b1;
      state.stable_pin       <= 1'b1;
      state.quiet_count      <= '0;
      state.servo_active     <= 1'b0;
      state.servo_count      <= '0;
    end else if (in_xfer) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      result_reg <= result;
    end
  end

  assign m_axis_tdata = result_reg;

  `GLSI_ASSERT_IMPLY(a_no_overwrite, in_xfer, !m_axis_tvalid || m_axis_tready,
                     "input taken while an unread result was stalled")
  `GLSI_ASSERT_IMPLY(a_gas_forces_fan, state.gas_alarm_on, state.fan_running,
                     "gas alarm active with the fan stopped")
  `GLSI_ASSERT_IMPLY(a_move_powers_servo, m_axis_tvalid && result_reg.valve_report,
                     result_reg.servo_power, "valve moved without servo power")
  `GLSI_ASSERT_IMPLY(a_refuse_alone, m_axis_tvalid && result_reg.refused,
                     !result_reg.fan_report && !result_reg.valve_report,
                     "refused command also reported a change")

endmodule

// ----- rtl/glsi_step.sv -----
// Next-state and result logic of the gas leak safety interlock for one item.
// Purely combinational; uses the types and codes of glsi_pkg.
module glsi_step import glsi_pkg::*; (
  input  state_t     state,
  input  cfg_t       cfg,
  input  logic [1:0] mode,
  input  logic [9:0] gas_sample,
  input  logic       pin_level,
  input  logic       command_on,
  output state_t     state_next,
  output result_t    result
);

  logic [15:0] quiet_next;
  logic        pin_accept;
  logic        fan_rep;
  logic        valve_rep;
  logic        refused;
  logic        moved;

  // Quiet counter as seen after this tick; the debounce compare uses the new value.
  always_comb begin
    if (pin_level != state.last_pin_seen) begin
      quiet_next = '0;
    end else if (state.quiet_count != COUNT_MAX) begin
      quiet_next = state.quiet_count + 16'd1;
    end else begin
      quiet_next = state.quiet_count;
    end
  end

  assign pin_accept = (quiet_next > cfg.debounce_ticks) && (pin_level != state.stable_pin);

  always_comb begin
    state_next = state;
    fan_rep    = 1'b0;
    valve_rep  = 1'b0;
    refused    = 1'b0;
    moved      = 1'b0;
    case (mode)
      MODE_TICK: begin
        state_next.quiet_count   = quiet_next;
        state_next.last_pin_seen = pin_level;
        if (pin_accept) begin
          state_next.stable_pin = pin_level;
          // A confirmed press (falling edge) toggles the valve.
          if (!pin_level) begin
            state_next.valve_closed_now = !state.valve_closed_now;
            state_next.servo_active     = 1'b1;
            state_next.servo_count      = '0;
            valve_rep                   = 1'b1;
            moved                       = 1'b1;
          end
        end
        if (state_next.servo_active && !moved && state.servo_count != COUNT_MAX) begin
          state_next.servo_count = state.servo_count + 16'd1;
        end
        if (state_next.servo_active && state_next.servo_count > cfg.servo_hold_ticks) begin
          state_next.servo_active = 1'b0;
        end
      end
      MODE_POLL: begin
        if (gas_sample > cfg.gas_alarm_level && !state.gas_alarm_on) begin
          state_next.gas_alarm_on = 1'b1;
          state_next.fan_running  = 1'b1;
          fan_rep                 = 1'b1;
        end else if (gas_sample < cfg.gas_clear_level && state.gas_alarm_on) begin
          state_next.gas_alarm_on = 1'b0;
          state_next.fan_running  = 1'b0;
          fan_rep                 = 1'b1;
        end
        if (!pin_level && !state.leak_alarm_on) begin
          state_next.leak_alarm_on    = 1'b1;
          state_next.valve_closed_now = 1'b1;
          state_next.servo_active     = 1'b1;
          state_next.servo_count      = '0;
          valve_rep                   = 1'b1;
        end else if (pin_level && state.leak_alarm_on) begin
          state_next.leak_alarm_on    = 1'b0;
          state_next.valve_closed_now = 1'b0;
          state_next.servo_active     = 1'b1;
          state_next.servo_count      = '0;
          valve_rep                   = 1'b1;
        end
      end
      MODE_FAN: begin
        if (command_on && !state.fan_running) begin
          state_next.fan_running = 1'b1;
          fan_rep                = 1'b1;
        end else if (!command_on && state.fan_running) begin
          if (state.gas_alarm_on) begin
            refused = 1'b1;
          end else begin
            state_next.fan_running = 1'b0;
            fan_rep                = 1'b1;
          end
        end
      end
      MODE_VALVE: begin
        if (!command_on && state.leak_alarm_on) begin
          refused = 1'b1;
        end else begin
          state_next.valve_closed_now = command_on;
          state_next.servo_active     = 1'b1;
          state_next.servo_count      = '0;
          valve_rep                   = 1'b1;
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

  assign result.fan_drive       = state_next.fan_running;
  assign result.valve_shut      = state_next.valve_closed_now;
  assign result.servo_power     = state_next.servo_active;
  assign result.gas_alarm_flag  = state_next.gas_alarm_on;
  assign result.leak_alarm_flag = state_next.leak_alarm_on;
  assign result.fan_report      = fan_rep;
  assign result.valve_report    = valve_rep;
  assign result.refused         = refused;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for gas_leak_safety_interlock_unit: streams ticks, polls and commands
// through the slave port, mirrors the interlock in a cycle-free predictor and checks each result.
// Depends on glsi_pkg and the RTL of the unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import glsi_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [1:0] mode;
    logic [9:0] gas;
    logic       pin;
    logic       cmd;
  } interlock_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [9:0] gas_sample, [10] pin_level, [11] command_on
  logic [1:0]  s_axis_tuser = '0;  // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] fan_drive, [1] valve_shut, [2] servo_power, [3] gas_alarm_flag,
  // [4] leak_alarm_flag, [5] fan_report, [6] valve_report, [7] refused
  logic [7:0]  m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  gas_leak_safety_interlock_unit dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  interlock_item_t pending_items[$];
  interlock_item_t item_on_bus;
  result_t         expected_results[$];
  result_t         predicted;
  result_t         want, got;
  int              failures = 0;
  int              stall_cycles = 0;
  int              tx_idle_pct = 0;
  int              rx_idle_pct = 0;

  // Mirror of the interlock configuration and state.
  logic [9:0]  alarm_level, clear_level;
  logic [15:0] debounce_len, servo_hold;
  logic        gas_on, leak_on, fan_on, valve_closed;
  logic        last_pin, stable_pin, servo_on;
  logic [15:0] quiet_cnt, servo_cnt;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic interlock_item_t make_item(logic [1:0] mode, logic [9:0] gas, logic pin,
                                                logic cmd);
    interlock_item_t it;
    it.mode = mode;
    it.gas  = gas;
    it.pin  = pin;
    it.cmd  = cmd;
    return it;
  endfunction

  task automatic shift_valve(input logic shut);
    valve_closed = shut;
    servo_on     = 1'b1;
    servo_cnt    = '0;
  endtask

  // Applies one accepted item to the mirrored state and returns the result it should produce.
  task automatic advance_interlock(input interlock_item_t it, output result_t r);
    logic moved;
    r     = '0;
    moved = 1'b0;
    case (it.mode)
      MODE_TICK: begin
        if (it.pin != last_pin) begin
          quiet_cnt = '0;
        end else if (quiet_cnt != COUNT_MAX) begin
          quiet_cnt = quiet_cnt + 16'd1;
        end
        last_pin = it.pin;
        if (quiet_cnt > debounce_len && it.pin != stable_pin) begin
          stable_pin = it.pin;
          // Only a confirmed falling edge (button press) toggles the valve.
          if (!it.pin) begin
            shift_valve(!valve_closed);
            r.valve_report = 1'b1;
            moved = 1'b1;
          end
        end
        if (servo_on && !moved && servo_cnt != COUNT_MAX) servo_cnt = servo_cnt + 16'd1;
        if (servo_on && servo_cnt > servo_hold) servo_on = 1'b0;
      end
      MODE_POLL: begin
        if (it.gas > alarm_level && !gas_on) begin
          gas_on = 1'b1;
          fan_on = 1'b1;
          r.fan_report = 1'b1;
        end else if (it.gas < clear_level && gas_on) begin
          gas_on = 1'b0;
          fan_on = 1'b0;
          r.fan_report = 1'b1;
        end
        if (!it.pin && !leak_on) begin
          leak_on = 1'b1;
          shift_valve(1'b1);
          r.valve_report = 1'b1;
        end else if (it.pin && leak_on) begin
          leak_on = 1'b0;
          shift_valve(1'b0);
          r.valve_report = 1'b1;
        end
      end
      MODE_FAN: begin
        if (it.cmd && !fan_on) begin
          fan_on = 1'b1;
          r.fan_report = 1'b1;
        end else if (!it.cmd && fan_on) begin
          if (gas_on) begin
            r.refused = 1'b1;
          end else begin
            fan_on = 1'b0;
            r.fan_report = 1'b1;
          end
        end
      end
      MODE_VALVE: begin
        if (!it.cmd && leak_on) begin
          r.refused = 1'b1;
        end else begin
          shift_valve(it.cmd);
          r.valve_report = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.fan_drive       = fan_on;
    r.valve_shut      = valve_closed;
    r.servo_power     = servo_on;
    r.gas_alarm_flag  = gas_on;
    r.leak_alarm_flag = leak_on;
  endtask

  task automatic check_bit(input string name, input logic exp_val, input logic act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0b, got %0b", name, exp_val, act_val);
      failures++;
    end
  endtask

  // Input driver: the item on the bus is predicted at the edge where its transfer completes.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        advance_interlock(item_on_bus, predicted);
        expected_results.push_back(predicted);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          item_on_bus = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, item_on_bus.cmd, item_on_bus.pin, item_on_bus.gas};
          s_axis_tuser  <= item_on_bus.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor and receiver stall.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no expected result pending: %02h", m_axis_tdata);
        failures++;
      end else begin
        want = expected_results.pop_front();
        got  = result_t'(m_axis_tdata);
        check_bit("fan_drive", want.fan_drive, got.fan_drive);
        check_bit("valve_shut", want.valve_shut, got.valve_shut);
        check_bit("servo_power", want.servo_power, got.servo_power);
        check_bit("gas_alarm_flag", want.gas_alarm_flag, got.gas_alarm_flag);
        check_bit("leak_alarm_flag", want.leak_alarm_flag, got.leak_alarm_flag);
        check_bit("fan_report", want.fan_report, got.fan_report);
        check_bit("valve_report", want.valve_report, got.valve_report);
        check_bit("refused", want.refused, got.refused);
      end
    end
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("testbench failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GAS_ALARM_LEVEL:  alarm_level  = value[9:0];
      REG_GAS_CLEAR_LEVEL:  clear_level  = value[9:0];
      REG_DEBOUNCE_TICKS:   debounce_len = value;
      REG_SERVO_HOLD_TICKS: servo_hold   = value;
      default: begin
      end
    endcase
  endtask

  task automatic configure(input logic [15:0] alarm, input logic [15:0] clear,
                           input logic [15:0] deb, input logic [15:0] hold);
    write_register(REG_GAS_ALARM_LEVEL, alarm);
    write_register(REG_GAS_CLEAR_LEVEL, clear);
    write_register(REG_DEBOUNCE_TICKS, deb);
    write_register(REG_SERVO_HOLD_TICKS, hold);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Tick runs that hold the pin, at times long enough to pass a short debouncer, polls near the
  // thresholds and commands; single ticks with a random pin act as bounce noise.
  task automatic queue_random_items(input int count);
    int n, run, k, level;
    logic p;
    interlock_item_t it;
    n = 0;
    while (n < count) begin
      k = $urandom_range(9);
      if (k < 4) begin
        p   = 1'($urandom_range(1));
        run = $urandom_range(1, (debounce_len < 10) ? debounce_len + 4 : 12);
        repeat (run) begin
          it = make_item(MODE_TICK, 10'($urandom_range(1023)), p, 1'($urandom_range(1)));
          pending_items.push_back(it);
          n++;
        end
      end else begin
        if (k == 4) begin
          it = make_item(MODE_TICK, 10'($urandom_range(1023)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
        end else if (k < 7) begin
          level = ($urandom_range(1) != 0) ? int'(alarm_level) : int'(clear_level);
          level = level + int'($urandom_range(4)) - 2;
          if ($urandom_range(3) == 0) level = int'($urandom_range(1023));
          if (level < 0) level = 0;
          if (level > 1023) level = 1023;
          it = make_item(MODE_POLL, 10'(level), ($urandom_range(4) != 0),
                         1'($urandom_range(1)));
        end else if (k == 7) begin
          it = make_item(MODE_FAN, 10'($urandom_range(1023)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
        end else begin
          it = make_item(MODE_VALVE, 10'($urandom_range(1023)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
        end
        pending_items.push_back(it);
        n++;
      end
    end
  endtask

  task automatic configure_random(input int phase);
    logic [9:0] a, c;
    logic [15:0] deb;
    a = 10'($urandom_range(1023));
    if ($urandom_range(1) != 0) begin
      c = (a > 10'd60) ? a - 10'($urandom_range(60)) : 10'd0;
    end else begin
      c = 10'($urandom_range(1023));
    end
    deb = (phase == 8) ? 16'($urandom_range(65535)) : 16'($urandom_range(6));
    // Upper data bits are don't-care for the 10-bit levels.
    configure({6'($urandom_range(63)), a}, {6'($urandom_range(63)), c}, deb,
              16'($urandom_range(20)));
  endtask

  initial begin
    alarm_level  = GAS_ALARM_LEVEL_RST;
    clear_level  = GAS_CLEAR_LEVEL_RST;
    debounce_len = DEBOUNCE_TICKS_RST;
    servo_hold   = SERVO_HOLD_TICKS_RST;
    gas_on       = 1'b0;
    leak_on      = 1'b0;
    fan_on       = 1'b0;
    valve_closed = 1'b0;
    last_pin     = 1'b1;
    stable_pin   = 1'b1;
    quiet_cnt    = '0;
    servo_on     = 1'b0;
    servo_cnt    = '0;
    tx_idle_pct  = 12;
    rx_idle_pct  = 63;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset thresholds: hysteresis edges, refusals and repeated commands.
    pending_items.push_back(make_item(MODE_POLL, 10'd1023, 1'b1, 1'b0));
    pending_items.push_back(make_item(MODE_FAN, 10'd0, 1'b1, 1'b0));
    pending_items.push_back(make_item(MODE_FAN, 10'd0, 1'b1, 1'b1));
    pending_items.push_back(make_item(MODE_POLL, 10'd380, 1'b1, 1'b0));
    pending_items.push_back(make_item(MODE_POLL, 10'd360, 1'b1, 1'b0));
    pending_items.push_back(make_item(MODE_POLL, 10'd0, 1'b0, 1'b1));
    pending_items.push_back(make_item(MODE_VALVE, 10'd0, 1'b1, 1'b0));
    pending_items.push_back(make_item(MODE_VALVE, 10'd0, 1'b1, 1'b1));
    pending_items.push_back(make_item(MODE_POLL, 10'd400, 1'b1, 1'b0));
    pending_items.push_back(make_item(MODE_POLL, 10'd401, 1'b1, 1'b0));
    pending_items.push_back(make_item(MODE_POLL, 10'd359, 1'b1, 1'b0));
    pending_items.push_back(make_item(MODE_FAN, 10'd1023, 1'b0, 1'b1));
    pending_items.push_back(make_item(MODE_FAN, 10'd1023, 1'b0, 1'b0));
    pending_items.push_back(make_item(MODE_VALVE, 10'd1023, 1'b0, 1'b0));
    queue_random_items(60);

    // Short debounce and servo window: a press toggles the valve, the release does not,
    // and the servo powers down once its window runs out.
    wait_drained();
    configure(GAS_ALARM_LEVEL_RST, GAS_CLEAR_LEVEL_RST, 16'd2, 16'd3);
    repeat (6) pending_items.push_back(make_item(MODE_TICK, 10'd0, 1'b0, 1'b0));
    repeat (5) pending_items.push_back(make_item(MODE_TICK, 10'd0, 1'b1, 1'b0));
    queue_random_items(60);

    for (int phase = 2; phase < 9; phase++) begin
      wait_drained();
      if (phase == 3) begin
        tx_idle_pct = 63;
        rx_idle_pct = 12;
      end else if (phase == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (phase == 2) configure(16'd0, 16'd0, 16'd0, 16'd0);
      else if (phase == 3) configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      else configure_random(phase);
      queue_random_items(70);
    end

    wait_drained();
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      failures++;
    end
    if (failures == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
